@@ hdl/lrupr_pkg.sv @@
`default_nettype none
package lrupr_pkg;

  localparam int FRAME_COUNT = 8;
  localparam int PAGE_BITS   = 16;

  localparam int IN_PAGE_W = 16;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 4;

  // Frame index width and the width that can hold the frame count itself.
  localparam int SLOT_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam int ACT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

  typedef struct packed {
    logic load;        // capture the page of a new item
    logic commit;      // apply the item to the frames and counters
    logic use_victim;  // commit replaces the oldest frame found by the scan
    logic scan_clear;  // restart the oldest-stamp scan at frame 0
    logic scan_step;   // examine one frame in the scan
  } cmd_t;

  typedef struct packed {
    logic hit_found;
    logic empty_found;
    logic scan_last;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/lrupr_ctrl.sv @@
`default_nettype none
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_EVICT
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_LOOKUP: begin
        cmd.commit     = status.hit_found || status.empty_found;
        cmd.scan_clear = !(status.hit_found || status.empty_found);
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_EVICT: begin
        cmd.commit     = 1'b1;
        cmd.use_victim = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= cmd.commit;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (status.hit_found || status.empty_found) begin
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/lrupr_dp.sv @@
`default_nettype none
module lrupr_dp
  import lrupr_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  cmd_t                 cmd,
  input  wire                  cfg_we,
  input  wire [CFG_W-1:0]      cfg_data,
  input  wire [IN_PAGE_W-1:0]  page_number,
  output status_t              status,
  output logic                 hit,
  output logic                 filled_empty,
  output logic [COUNT_W-1:0]   fault_total,
  output logic [COUNT_W-1:0]   hit_total
);

  logic [CFG_W-1:0]     frames_in_use;
  logic [ACT_W-1:0]     cfg_wide;
  logic [ACT_W-1:0]     n_active;

  logic                 frame_valid [FRAME_COUNT];
  logic [PAGE_BITS-1:0] frame_page  [FRAME_COUNT];
  logic [STAMP_W-1:0]   frame_stamp [FRAME_COUNT];

  logic [STAMP_W-1:0]   ref_clock;
  logic [COUNT_W-1:0]   fault_counter;
  logic [COUNT_W-1:0]   hit_counter;
  logic [PAGE_BITS-1:0] page;

  logic                 match_found;
  logic [SLOT_W-1:0]    match_slot;
  logic                 empty_found;
  logic [SLOT_W-1:0]    empty_slot;

  logic [SLOT_W-1:0]    scan_idx;
  logic [STAMP_W-1:0]   best_age;
  logic [SLOT_W-1:0]    best_slot;
  logic [STAMP_W-1:0]   scan_age;
  logic [SLOT_W-1:0]    write_slot;

  // Out-of-range counts are clamped: zero acts as one, above the build acts as the build.
  assign cfg_wide = ACT_W'(frames_in_use);
  always_comb begin
    priority if (cfg_wide == '0) begin
      n_active = ACT_W'(1);
    end else if (cfg_wide > ACT_W'(FRAME_COUNT)) begin
      n_active = ACT_W'(FRAME_COUNT);
    end else begin
      n_active = cfg_wide;
    end
  end

  // Lowest-numbered matching frame and lowest-numbered empty frame among the active ones.
  always_comb begin
    match_found = 1'b0;
    match_slot  = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    for (int k = FRAME_COUNT - 1; k >= 0; k--) begin
      if (ACT_W'(k) < n_active) begin
        if (frame_valid[k] && (frame_page[k] == page)) begin
          match_found = 1'b1;
          match_slot  = SLOT_W'(k);
        end
        if (!frame_valid[k]) begin
          empty_found = 1'b1;
          empty_slot  = SLOT_W'(k);
        end
      end
    end
  end

  assign scan_age = ref_clock - frame_stamp[scan_idx];

  assign status.hit_found   = match_found;
  assign status.empty_found = empty_found;
  assign status.scan_last   = (ACT_W'(scan_idx) + ACT_W'(1)) == n_active;

  always_comb begin
    priority if (cmd.use_victim) begin
      write_slot = best_slot;
    end else if (match_found) begin
      write_slot = match_slot;
    end else begin
      write_slot = empty_slot;
    end
  end

  assign fault_total = fault_counter;
  assign hit_total   = hit_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
      ref_clock     <= '0;
      fault_counter <= '0;
      hit_counter   <= '0;
      for (int k = 0; k < FRAME_COUNT; k++) begin
        frame_valid[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (cmd.commit) begin
        frame_stamp[write_slot] <= ref_clock;
        ref_clock <= ref_clock + STAMP_W'(1);
        if (!cmd.use_victim && match_found) begin
          hit_counter <= (hit_counter == '1) ? hit_counter : hit_counter + COUNT_W'(1);
        end else begin
          frame_valid[write_slot] <= 1'b1;
          frame_page[write_slot]  <= page;
          fault_counter <= (fault_counter == '1) ? fault_counter
                                                 : fault_counter + COUNT_W'(1);
        end
      end
    end
  end

  // Payload and scan registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= PAGE_BITS'(page_number);
    end
    if (cmd.commit) begin
      hit          <= !cmd.use_victim && match_found;
      filled_empty <= !cmd.use_victim && !match_found;
    end
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      // Strict compare keeps the lowest index on equal ages.
      if ((scan_idx == '0) || (scan_age > best_age)) begin
        best_age  <= scan_age;
        best_slot <= scan_idx;
      end
      scan_idx <= scan_idx + SLOT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ hdl/lru_page_replacement.sv @@
// A hit or a fill of an empty frame passes from accept through the lookup state to the done strobe.
// An eviction passes through lookup, the oldest-stamp scan of the N active frames at one
// frame per cycle, and the evict state. One item is in flight at a time.
// Results show for one cycle on done; the receiver cannot stall them.
// Reset (synchronous, rst high) empties all frames, zeroes the clock and counters and sets
// frames_in_use to 8.
`default_nettype none
module lru_page_replacement
  import lrupr_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  // Item channel: accepted when start is high and busy is low.
  input  wire                  start,
  output logic                 busy,
  input  wire [IN_PAGE_W-1:0]  page_number,
  // Result: valid for the single cycle in which done is high.
  output logic                 done,
  output logic                 hit,
  output logic                 filled_empty,
  output logic [COUNT_W-1:0]   fault_total,
  output logic [COUNT_W-1:0]   hit_total,
  // Configuration write channel for frames_in_use.
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_W-1:0]      cfg_data
);

  // The controller sequences each item: a lookup cycle that resolves hits and
  // fills of empty frames directly, and otherwise a scan over the active
  // frames that tracks the oldest stamp, followed by a cycle that replaces it.
  // The datapath holds the frame table, the reference clock and the counters.

  cmd_t    cmd;
  status_t status;

  // Configuration is taken whenever no item is in progress.
  assign cfg_ready = !busy;

  lrupr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The running totals come straight from the counters, which hold the
  // post-item values from the commit until the next item commits.
  lrupr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .page_number  (page_number),
    .status       (status),
    .hit          (hit),
    .filled_empty (filled_empty),
    .fault_total  (fault_total),
    .hit_total    (hit_total)
  );

endmodule
`default_nettype wire
